// File: sv/arp_cache_engine_defines.svh
// Assertion helpers for the ARP cache RTL.
`ifndef ARP_CACHE_ENGINE_DEFINES_SVH
`define ARP_CACHE_ENGINE_DEFINES_SVH

// Clocked check, masked while reset is held (active low).
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ARPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/arpc_pkg.sv
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 2'd1;

    localparam logic [IP_W-1:0] OWN_IP_RST = 32'hC0A8_0102;

    // Item opcodes
    localparam logic OPC_LOOKUP = 1'b0;
    localparam logic OPC_ARP    = 1'b1;

    // ARP header constants
    localparam logic [FIELD_W-1:0] HW_ETHERNET  = 16'h0001;
    localparam logic [FIELD_W-1:0] PROTO_IPV4   = 16'h0800;
    localparam logic [FIELD_W-1:0] OPER_REQUEST = 16'h0001;
    localparam logic [FIELD_W-1:0] OPER_REPLY   = 16'h0002;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_UPDATED = 3'd2,
        ST_ADDED   = 3'd3,
        ST_FULL    = 3'd4,
        ST_REPLY   = 3'd5,
        ST_IGNORED = 3'd6,
        ST_BADTYPE = 3'd7
    } t_status;

    typedef struct packed {
        logic               opcode;
        logic [IP_W-1:0]    ip_addr;
        logic [MAC_W-1:0]   mac_addr;
        logic [IP_W-1:0]    target_ip;
        logic [FIELD_W-1:0] hw_type;
        logic [FIELD_W-1:0] proto_type;
        logic [FIELD_W-1:0] arp_op;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic [MAC_W-1:0] mac_out;
        logic [IP_W-1:0]  ip_out;
    } t_result;

    // Controller -> datapath
    typedef struct packed {
        logic latch;
        logic quick;
        logic scan_start;
        logic scan;
        logic resolve;
        logic mac_take;
        logic out_load;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic lookup_hit;
        logic out_free;
    } t_stat;

endpackage

// File: sv/arpc_ifs.sv
`timescale 1ns / 1ps

// Input item channel
interface arpc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [arpc_pkg::IP_W-1:0]     ip_addr;
    logic [arpc_pkg::MAC_W-1:0]    mac_addr;
    logic [arpc_pkg::IP_W-1:0]     target_ip;
    logic [arpc_pkg::FIELD_W-1:0]  hw_type;
    logic [arpc_pkg::FIELD_W-1:0]  proto_type;
    logic [arpc_pkg::FIELD_W-1:0]  arp_op;

    modport source (output valid, opcode, ip_addr, mac_addr, target_ip, hw_type,
                    proto_type, arp_op, input ready);
    modport sink   (input valid, opcode, ip_addr, mac_addr, target_ip, hw_type,
                    proto_type, arp_op, output ready);
endinterface

// Result channel
interface arpc_out_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  status;
    logic [arpc_pkg::MAC_W-1:0]  mac_out;
    logic [arpc_pkg::IP_W-1:0]   ip_out;

    modport source (output valid, status, mac_out, ip_out, input ready);
    modport sink   (input valid, status, mac_out, ip_out, output ready);
endinterface

// Configuration write channel
interface arpc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [arpc_pkg::CFG_IDX_W-1:0]  index;
    logic [arpc_pkg::MAC_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/arp_cache_engine.sv
`timescale 1ns / 1ps
// ARP cache: resolves IPv4 addresses to MAC addresses from a table of
// TABLE_ENTRIES entries and learns entries from received ARP replies. Each
// word on i_in gives exactly one word on o_out. Lookups of the own IP,
// bad-type packets, requests and other packets that need no search go
// from decode straight to the output stage.
// Lookups of other addresses and well-typed ARP replies from other addresses
// search the table one entry per cycle through the single read port of the IP
// memory; a lookup hit then takes an extra step to read the MAC memory.
// A finished word sits in an output register, so the next word is taken
// while it waits. The own IP (index 0) and own MAC (index 1) are written
// through i_cfg, which is always ready; other indexes are ignored. After
// reset entry 0 holds all ones and the other entries hold zero; no clearing
// pass is needed.

module arp_cache_engine #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    arpc_in_if.sink       i_in,
    arpc_out_if.source    o_out,
    arpc_cfg_if.sink      i_cfg
);

    arpc_pkg::t_cmd    cmd;
    arpc_pkg::t_stat   stat;
    arpc_pkg::t_item   item;
    arpc_pkg::t_result res;
    logic              res_valid;
    logic              in_ready;

    // Input word to item struct
    always_comb begin
        item.opcode     = i_in.opcode;
        item.ip_addr    = i_in.ip_addr;
        item.mac_addr   = i_in.mac_addr;
        item.target_ip  = i_in.target_ip;
        item.hw_type    = i_in.hw_type;
        item.proto_type = i_in.proto_type;
        item.arp_op     = i_in.arp_op;
    end

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid   = res_valid;
    assign o_out.status  = res.status;
    assign o_out.mac_out = res.mac_out;
    assign o_out.ip_out  = res.ip_out;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    arpc_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (o_out.ready)
    );

endmodule

// File: sv/arpc_ctrl.sv
`timescale 1ns / 1ps
`include "arp_cache_engine_defines.svh"

module arpc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  arpc_pkg::t_stat i_stat,
    output arpc_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DEC     = 6'b000010,
        S_SCAN    = 6'b000100,
        S_RESOLVE = 6'b001000,
        S_MACRD   = 6'b010000,
        S_OUT     = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.need_scan) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.quick = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = i_stat.lookup_hit ? S_MACRD : S_OUT;
            end
            S_MACRD: begin
                o_cmd.mac_take = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ARPC_ASSERT(a_accept_to_dec, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_DEC), "accepted word did not reach decode")
    `ARPC_ASSERT(a_done_only_in_scan, i_clk, i_rst_n, i_stat.scan_done |-> (r_state == S_SCAN), "search finished outside scan")
    `ARPC_ASSERT(a_macrd_after_resolve, i_clk, i_rst_n, (r_state == S_MACRD) |-> ($past(r_state) == S_RESOLVE), "mac read without resolve")
    `ARPC_ASSERT(a_load_into_free, i_clk, i_rst_n, o_cmd.out_load |-> i_stat.out_free, "result loaded over a pending word")

endmodule

// File: sv/arpc_dp.sv
`timescale 1ns / 1ps

module arpc_dp #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  arpc_pkg::t_cmd                 i_cmd,
    output arpc_pkg::t_stat                o_stat,
    input  arpc_pkg::t_item                i_item,
    input  logic                           i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [arpc_pkg::MAC_W-1:0]     i_cfg_data,
    output arpc_pkg::t_result              o_res,
    output logic                           o_res_valid,
    input  logic                           i_res_ready
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    // Configuration registers
    logic [arpc_pkg::IP_W-1:0]  r_own_ip;
    logic [arpc_pkg::MAC_W-1:0] r_own_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= arpc_pkg::OWN_IP_RST;
            r_own_mac <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                arpc_pkg::REG_OWN_IP:  r_own_ip  <= i_cfg_data[arpc_pkg::IP_W-1:0];
                arpc_pkg::REG_OWN_MAC: r_own_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latched item
    arpc_pkg::t_item r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
    end

    // Decode of the latched item
    logic              is_lookup;
    logic              type_ok;
    logic              ip_local;
    logic              need_scan;
    arpc_pkg::t_result quick_res;

    always_comb begin
        is_lookup = (r_item.opcode == arpc_pkg::OPC_LOOKUP);
        type_ok   = (r_item.hw_type == arpc_pkg::HW_ETHERNET) &&
                    (r_item.proto_type == arpc_pkg::PROTO_IPV4);
        ip_local  = (r_item.ip_addr == r_own_ip);
        need_scan = is_lookup ? !ip_local
                              : (type_ok && (r_item.arp_op == arpc_pkg::OPER_REPLY) &&
                                 !ip_local);
        quick_res.mac_out = '0;
        quick_res.ip_out  = '0;
        if (is_lookup) begin
            quick_res.status  = arpc_pkg::ST_HIT;
            quick_res.mac_out = r_own_mac;
        end else if (!type_ok) begin
            quick_res.status = arpc_pkg::ST_BADTYPE;
        end else if ((r_item.arp_op == arpc_pkg::OPER_REQUEST) &&
                     (r_item.target_ip == r_own_ip)) begin
            quick_res.status  = arpc_pkg::ST_REPLY;
            quick_res.mac_out = r_item.mac_addr;
            quick_res.ip_out  = r_item.ip_addr;
        end else begin
            // replies for our own address, requests for other targets and other operations
            quick_res.status = arpc_pkg::ST_IGNORED;
        end
    end

    // Table storage: memories plus per-entry written flags
    logic [arpc_pkg::IP_W-1:0]  r_mem_ip  [TABLE_ENTRIES];
    logic [arpc_pkg::MAC_W-1:0] r_mem_mac [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   r_ip_vld;
    logic [TABLE_ENTRIES-1:0]   r_mac_vld;

    logic [arpc_pkg::IP_W-1:0]  r_ip_q;
    logic                       r_ip_qv;
    logic                       r_ip_q0;
    logic [arpc_pkg::MAC_W-1:0] r_mac_q;
    logic                       r_mac_qv;
    logic                       r_mac_q0;

    // Search pipeline
    logic [IW-1:0] r_rd_addr;
    logic          r_rd_busy;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    logic          r_found;
    logic          r_have_free;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_free_idx;

    logic                       ip_we;
    logic                       mac_we;
    logic [IW-1:0]              wr_idx;
    logic [arpc_pkg::IP_W-1:0]  ip_eff;
    logic [arpc_pkg::MAC_W-1:0] mac_eff;
    logic                       cmp_match;
    logic                       cmp_free;

    // Unwritten entries read as their reset contents
    always_comb begin
        ip_eff    = r_ip_qv ? r_ip_q : (r_ip_q0 ? '1 : '0);
        mac_eff   = r_mac_qv ? r_mac_q : (r_mac_q0 ? '1 : '0);
        cmp_match = (ip_eff == r_item.ip_addr);
        cmp_free  = (ip_eff[arpc_pkg::IP_W-1 -: 8] == 8'd0);
        ip_we     = i_cmd.resolve && !is_lookup && !r_found && r_have_free;
        mac_we    = i_cmd.resolve && !is_lookup && (r_found || r_have_free);
        wr_idx    = r_found ? r_hit_idx : r_free_idx;
    end

    always_ff @(posedge i_clk) begin
        if (ip_we) begin
            r_mem_ip[r_free_idx] <= r_item.ip_addr;
        end
        if (mac_we) begin
            r_mem_mac[wr_idx] <= r_item.mac_addr;
        end
        r_ip_q   <= r_mem_ip[r_rd_addr];
        r_ip_qv  <= r_ip_vld[r_rd_addr];
        r_ip_q0  <= (r_rd_addr == '0);
        r_mac_q  <= r_mem_mac[r_hit_idx];
        r_mac_qv <= r_mac_vld[r_hit_idx];
        r_mac_q0 <= (r_hit_idx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_vld  <= '0;
            r_mac_vld <= '0;
        end else begin
            if (ip_we) begin
                r_ip_vld[r_free_idx] <= 1'b1;
            end
            if (mac_we) begin
                r_mac_vld[wr_idx] <= 1'b1;
            end
        end
    end

    // Read address walks the table once; compare works on the registered read in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_busy   <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_rd_busy   <= 1'b1;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan && r_rd_busy;
            if (i_cmd.scan && r_rd_busy && (r_rd_addr == LAST)) begin
                r_rd_busy <= 1'b0;
            end
            if (r_cmp_vld && cmp_match) begin
                r_found <= 1'b1;
            end
            if (r_cmp_vld && cmp_free) begin
                r_have_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd_addr <= '0;
        end else if (i_cmd.scan && r_rd_busy && (r_rd_addr != LAST)) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
        if (i_cmd.scan && r_rd_busy) begin
            r_cmp_idx <= r_rd_addr;
        end
        // first matching and first free entries win
        if (r_cmp_vld && cmp_match && !r_found) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (r_cmp_vld && cmp_free && !r_have_free) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    // Result register
    arpc_pkg::t_result r_res;
    arpc_pkg::t_result resolve_res;

    always_comb begin
        resolve_res.mac_out = '0;
        resolve_res.ip_out  = '0;
        if (is_lookup) begin
            resolve_res.status = arpc_pkg::ST_MISS;
        end else if (r_found) begin
            resolve_res.status = arpc_pkg::ST_UPDATED;
        end else if (r_have_free) begin
            resolve_res.status = arpc_pkg::ST_ADDED;
        end else begin
            resolve_res.status = arpc_pkg::ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.quick) begin
            r_res <= quick_res;
        end else if (i_cmd.resolve) begin
            r_res <= resolve_res;
        end else if (i_cmd.mac_take) begin
            r_res.status  <= arpc_pkg::ST_HIT;
            r_res.mac_out <= mac_eff;
            r_res.ip_out  <= '0;
        end
    end

    // Output word register
    logic              r_o_vld;
    arpc_pkg::t_result r_o_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_res <= r_res;
        end
    end

    assign o_res       = r_o_res;
    assign o_res_valid = r_o_vld;

    always_comb begin
        o_stat.need_scan  = need_scan;
        o_stat.scan_done  = r_cmp_vld && (r_cmp_idx == LAST);
        o_stat.lookup_hit = is_lookup && r_found;
        o_stat.out_free   = !r_o_vld || i_res_ready;
    end

endmodule
